// ===== sv/track_speed_inverse_kinematics_top_assert.svh =====
// Assertion macros for the track speed inverse kinematics block.
`ifndef TRACK_SPEED_INVERSE_KINEMATICS_TOP_ASSERT_SVH
`define TRACK_SPEED_INVERSE_KINEMATICS_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define TSIK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TSIK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tsik_pkg.sv =====
// Shared types, constants and tables for the track speed inverse kinematics block.
package tsik_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  localparam int CW  = 34;          // CORDIC x/y/z, Q2.30 with headroom
  localparam int PW  = CW + 16;     // cos/sin times velocity
  localparam int DW  = PW + 1;      // rotated sum
  localparam int LXW = DW - 22;     // local_x, Q.16
  localparam int BW  = 33;          // base_coeff times turn_rate
  localparam int RW  = LXW + 17;    // radius_coeff times local_x
  localparam int AW  = RW + 1;      // final accumulator, Q.32
  localparam int QW  = AW - 24;     // accumulator rounded to Q.8

  typedef logic signed [CW-1:0] cord_t;
  typedef logic signed [15:0]   s16_t;

  typedef struct packed {
    logic flip;
    s16_t vel_x;
    s16_t vel_y;
    s16_t turn_rate;
  } cargo_t;

  typedef struct packed {
    cord_t  x;
    cord_t  y;
    cord_t  z;
    cargo_t cargo;
  } cordic_t;

  typedef enum logic [1:0] {
    REG_OUTPUT_ENABLE = 2'd0,
    REG_RADIUS_COEFF  = 2'd1,
    REG_BASE_COEFF    = 2'd2
  } reg_idx_t;

  localparam cord_t CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;

  localparam logic [15:0] RADIUS_RESET = 16'd5747;
  localparam logic [15:0] BASE_RESET   = 16'd17236;

  localparam s16_t SAT_MAX = 16'sh7FFF;
  localparam s16_t SAT_MIN = 16'sh8000;

  localparam logic signed [DW-1:0] ROUND22     = DW'(64'sd2097152);
  localparam logic signed [DW-1:0] ROUND22_NEG = DW'(64'sd2097153);  // ~d + 1 + half
  localparam logic signed [AW-1:0] ROUND24     = AW'(64'sd8388608);

  // atan(2^-i) in Q2.30, truncated
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage

// ===== sv/tsik_cordic.sv =====
// Heading reduction and pipelined rotation-mode CORDIC, one iteration per stage.
module tsik_cordic import tsik_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  logic    output_enable,
  input  s16_t    heading,
  input  s16_t    vel_x,
  input  s16_t    vel_y,
  input  s16_t    turn_rate,
  output logic    out_valid,
  input  logic    out_ready,
  output cordic_t out_data
);

  logic    v   [0:CORDIC_STAGES];
  cordic_t d   [0:CORDIC_STAGES];
  logic    rdy [0:CORDIC_STAGES+1];

  logic signed [16:0] hs;
  logic signed [16:0] hx;
  logic               flip0;

  assign rdy[CORDIC_STAGES+1] = out_ready;
  assign cmd_ready            = rdy[0];
  assign out_valid            = v[CORDIC_STAGES];
  assign out_data             = d[CORDIC_STAGES];

  for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  // fold heading into [-pi/2, pi/2]; the folded quadrants flip cos and sin
  always_comb begin
    hs    = 17'(heading);
    hx    = hs;
    flip0 = 1'b0;
    if (hs > HALF_PI_Q13) begin
      hx    = hs - PI_Q13;
      flip0 = 1'b1;
    end else if (hs < -HALF_PI_Q13) begin
      hx    = hs + PI_Q13;
      flip0 = 1'b1;
    end
  end

  // disabled requests are taken and dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= cmd_valid && output_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && cmd_valid) begin
      d[0].x               <= CORDIC_GAIN;
      d[0].y               <= '0;
      d[0].z               <= cord_t'({hx, 17'd0});
      d[0].cargo.flip      <= flip0;
      d[0].cargo.vel_x     <= vel_x;
      d[0].cargo.vel_y     <= vel_y;
      d[0].cargo.turn_rate <= turn_rate;
    end
  end

  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_iter
    localparam cord_t ATAN = cord_t'({2'b00, ATAN_Q30[k-1]});
    cordic_t nx;

    always_comb begin
      nx = d[k-1];
      if (!d[k-1].z[CW-1]) begin
        nx.x = d[k-1].x - (d[k-1].y >>> (k-1));
        nx.y = d[k-1].y + (d[k-1].x >>> (k-1));
        nx.z = d[k-1].z - ATAN;
      end else begin
        nx.x = d[k-1].x + (d[k-1].y >>> (k-1));
        nx.y = d[k-1].y - (d[k-1].x >>> (k-1));
        nx.z = d[k-1].z + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v[k-1]) begin
        d[k] <= nx;
      end
    end
  end

endmodule

// ===== sv/tsik_mix.sv =====
// Rotation into the local frame, track gains, rounding and saturation (five stages).
module tsik_mix import tsik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cordic_t     in_data,
  input  logic [15:0] radius_coeff,
  input  logic [15:0] base_coeff,
  output logic        res_valid,
  input  logic        res_ready,
  output s16_t        left_speed,
  output s16_t        right_speed
);

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  logic signed [PW-1:0]  pc1, ps1;
  logic signed [BW-1:0]  pw1, pw2, pw3;
  logic                  flip1, flip2;
  logic signed [DW-1:0]  d2;
  logic signed [DW-1:0]  t3;
  logic signed [LXW-1:0] lx3;
  logic signed [RW-1:0]  pr4;
  logic signed [AW-1:0]  pb4;
  logic signed [AW-1:0]  acc5;
  logic signed [QW-1:0]  q5;
  s16_t                  lsat, rsat;

  assign r5       = !v5 || res_ready;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;
  assign res_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      pc1   <= in_data.x * in_data.cargo.vel_x;
      ps1   <= in_data.y * in_data.cargo.vel_y;
      pw1   <= $signed({1'b0, base_coeff}) * in_data.cargo.turn_rate;
      flip1 <= in_data.cargo.flip;
    end
  end

  // stage 2: cos*vx - sin*vy
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      d2    <= DW'(pc1) - DW'(ps1);
      pw2   <= pw1;
      flip2 <= flip1;
    end
  end

  // stage 3: negate for folded headings and round to Q.16; -d + half = ~d + half + 1
  assign t3 = (flip2 ? ~d2 : d2) + (flip2 ? ROUND22_NEG : ROUND22);

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      lx3 <= LXW'(t3 >>> 22);
      pw3 <= pw2;
    end
  end

  // stage 4: radius gain; turn term moved to Q.32 with the rounding half folded in
  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      pr4 <= $signed({1'b0, radius_coeff}) * lx3;
      pb4 <= (AW'(pw3) <<< 8) + ROUND24;
    end
  end

  // stage 5: sum, round to Q.8, saturate
  always_comb begin
    acc5 = AW'(pr4) + pb4;
    q5   = QW'(acc5 >>> 24);
    if (q5 > QW'(SAT_MAX)) begin
      lsat = SAT_MAX;
    end else if (q5 < QW'(SAT_MIN)) begin
      lsat = SAT_MIN;
    end else begin
      lsat = q5[15:0];
    end
    rsat = (lsat == SAT_MIN) ? SAT_MAX : -lsat;
  end

  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      left_speed  <= lsat;
      right_speed <= rsat;
    end
  end

endmodule

// ===== sv/track_speed_inverse_kinematics_top.sv =====
// Throughput: one request per cycle unless a result stalls; each CORDIC iteration has a stage.
// A stalled result parks in its stage; bubbles ahead of it still fill, then cmd_ready drops.
// Requests taken while output_enable is 0 are dropped at the first stage.
// Reset (rst, synchronous) clears all valid bits and returns the registers to their defaults.
// Register map: 0x0 output_enable, 0x4 radius_coeff, 0x8 base_coeff.
module track_speed_inverse_kinematics_top import tsik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  s16_t        heading,
  input  s16_t        vel_x,
  input  s16_t        vel_y,
  input  s16_t        turn_rate,
  output logic        res_valid,
  input  logic        res_ready,
  output s16_t        left_speed,
  output s16_t        right_speed
);

  logic        output_enable;
  logic [15:0] radius_coeff;
  logic [15:0] base_coeff;
  reg_idx_t    reg_idx;

  logic        cor_valid;
  logic        cor_ready;
  cordic_t     cor_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enable <= 1'b0;
      radius_coeff  <= RADIUS_RESET;
      base_coeff    <= BASE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_OUTPUT_ENABLE: output_enable <= pwdata[0];
        REG_RADIUS_COEFF:  radius_coeff  <= pwdata[15:0];
        REG_BASE_COEFF:    base_coeff    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OUTPUT_ENABLE: prdata = {31'd0, output_enable};
      REG_RADIUS_COEFF:  prdata = {16'd0, radius_coeff};
      REG_BASE_COEFF:    prdata = {16'd0, base_coeff};
      default:           prdata = '0;
    endcase
  end

  tsik_cordic u_cordic (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .output_enable (output_enable),
    .heading       (heading),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .turn_rate     (turn_rate),
    .out_valid     (cor_valid),
    .out_ready     (cor_ready),
    .out_data      (cor_data)
  );

  tsik_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (cor_valid),
    .in_ready     (cor_ready),
    .in_data      (cor_data),
    .radius_coeff (radius_coeff),
    .base_coeff   (base_coeff),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .left_speed   (left_speed),
    .right_speed  (right_speed)
  );

endmodule

// ===== sv/tsik_checker.sv =====
// Port-level assertions for the track speed inverse kinematics block, bound to the top level.
`include "track_speed_inverse_kinematics_top_assert.svh"

module tsik_checker import tsik_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input s16_t left_speed,
  input s16_t right_speed
);

  `TSIK_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(left_speed) && $stable(right_speed), "stalled result changed")

  `TSIK_ASSERT_NOW(a_right_neg, res_valid && (left_speed != SAT_MIN), right_speed == -left_speed, "right speed is not negated left")

  `TSIK_ASSERT_NOW(a_right_sat, res_valid && (left_speed == SAT_MIN), right_speed == SAT_MAX, "right speed not saturated")

  `TSIK_ASSERT_NOW(a_backpressure, !cmd_ready, res_valid && !res_ready, "request refused without a stalled result")

  `TSIK_ASSERT_NOW(a_reset_empty, $past(rst), !res_valid, "result present right after reset")

endmodule

bind track_speed_inverse_kinematics_top tsik_checker u_tsik_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .left_speed  (left_speed),
  .right_speed (right_speed)
);

// ===== tb/track_speed_inverse_kinematics_top_test.sv =====
// Self-checking testbench for the track speed inverse kinematics block.
module track_speed_inverse_kinematics_top_test;
  import tsik_pkg::*;

  localparam int SETTLE = CORDIC_STAGES + 16;   // CORDIC depth plus margin
  localparam logic [1:0] UNUSED_REG = 2'd3;     // decodes to nothing

  // atan(2^-i) in Q2.30, truncated
  localparam longint ARCTAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct packed {
    s16_t heading;
    s16_t vel_x;
    s16_t vel_y;
    s16_t turn_rate;
  } cmd_t;

  typedef struct {
    cmd_t req;
    s16_t left;
    s16_t right;
  } track_pair_t;

  bit clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  s16_t heading = '0;
  s16_t vel_x = '0;
  s16_t vel_y = '0;
  s16_t turn_rate = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  s16_t left_speed;
  s16_t right_speed;

  // register mirror
  logic enable_q = 1'b0;
  logic [15:0] radius_q = RADIUS_RESET;
  logic [15:0] base_q = BASE_RESET;

  cmd_t cmd_backlog[$];
  track_pair_t pending_tracks[$];
  logic cmd_fire = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_cnt = 0;

  track_speed_inverse_kinematics_top u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .heading(heading),
    .vel_x(vel_x),
    .vel_y(vel_y),
    .turn_rate(turn_rate),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .left_speed(left_speed),
    .right_speed(right_speed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic track_pair_t predict_tracks(cmd_t c);
    longint h, x, y, z, nx, cs, sn, local_x, acc, left, right;
    bit flip;
    track_pair_t t;
    h = c.heading;
    flip = 1'b0;
    if (h > longint'(HALF_PI_Q13)) begin
      h = h - longint'(PI_Q13);
      flip = 1'b1;
    end else if (h < -longint'(HALF_PI_Q13)) begin
      h = h + longint'(PI_Q13);
      flip = 1'b1;
    end
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = h * 131072;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARCTAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARCTAN_Q30[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
    // round half up at each narrowing
    local_x = (cs * c.vel_x - sn * c.vel_y + (longint'(1) << 21)) >>> 22;
    acc = longint'(radius_q) * local_x + longint'(base_q) * c.turn_rate * 256;
    left = (acc + (longint'(1) << 23)) >>> 24;
    if (left > 32767) left = 32767;
    else if (left < -32768) left = -32768;
    right = -left;
    if (right > 32767) right = 32767;
    t.req = c;
    t.left = s16_t'(left);
    t.right = s16_t'(right);
    return t;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // request driver
  always @(negedge clk) begin
    cmd_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_fire) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        heading <= nxt.heading;
        vel_x <= nxt.vel_x;
        vel_y <= nxt.vel_y;
        turn_rate <= nxt.turn_rate;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: predict on request, check on result
  always @(posedge clk) begin
    track_pair_t want;
    cmd_t req;
    cmd_fire <= !rst && cmd_valid && cmd_ready;
    if (!rst) begin
      if (cmd_valid && cmd_ready && enable_q) begin
        req = '{heading, vel_x, vel_y, turn_rate};
        pending_tracks.push_back(predict_tracks(req));
      end
      if (res_valid && res_ready) begin
        if (pending_tracks.size() == 0) begin
          note_mismatch($sformatf("unexpected result left %0d right %0d",
                                  left_speed, right_speed));
        end else begin
          want = pending_tracks.pop_front();
          if (left_speed !== want.left || right_speed !== want.right)
            note_mismatch($sformatf(
              "mismatch h=%0d vx=%0d vy=%0d w=%0d: exp left %0d right %0d, got %0d %0d",
              want.req.heading, want.req.vel_x, want.req.vel_y, want.req.turn_rate,
              want.left, want.right, left_speed, right_speed));
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OUTPUT_ENABLE: enable_q = val[0];
      REG_RADIUS_COEFF:  radius_q = val[15:0];
      REG_BASE_COEFF:    base_q = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // all requests taken, all results back, pipeline flushed
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || pending_tracks.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic queue_req(input int h, input int vx, input int vy, input int w);
    cmd_backlog.push_back('{s16_t'(h), s16_t'(vx), s16_t'(vy), s16_t'(w)});
  endtask

  function automatic s16_t rand_word();
    case ($urandom_range(0, 9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return s16_t'(int'($urandom_range(0, 512)) - 256);
      default: return s16_t'($urandom);
    endcase
  endfunction

  // bias toward the quadrant fold points
  function automatic s16_t rand_heading();
    int pick;
    int v;
    pick = $urandom_range(0, 7);
    if (pick < 2) begin
      v = (pick == 0 ? int'(HALF_PI_Q13) : int'(PI_Q13)) + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1)) v = -v;
      return s16_t'(v);
    end
    if (pick == 2) return rand_word();
    return s16_t'($urandom);
  endfunction

  task automatic queue_random(input int n);
    repeat (n) cmd_backlog.push_back('{rand_heading(), rand_word(), rand_word(), rand_word()});
  endtask

  task automatic run_phase(input logic [15:0] radius, input logic [15:0] base, input int n);
    write_reg(REG_RADIUS_COEFF, {16'($urandom), radius});
    write_reg(REG_BASE_COEFF, {16'($urandom), base});
    queue_random(n / 2);
    wait_idle();    // sender holds off until everything is back
    queue_random(n - n / 2);
    wait_idle();
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 45;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // output disabled out of reset: nothing should come back
    queue_req(0, 256, 256, 256);
    queue_req(32767, 32767, 32767, 32767);
    queue_req(-32768, -32768, -32768, -32768);
    queue_req(12869, -100, 200, -300);
    wait_idle();

    write_reg(UNUSED_REG, $urandom);
    write_reg(REG_OUTPUT_ENABLE, {31'($urandom), 1'b1});

    // default gains: zero, extremes, fold boundaries
    queue_req(0, 0, 0, 0);
    queue_req(32767, 32767, 32767, 32767);
    queue_req(-32768, -32768, -32768, -32768);
    queue_req(12868, 256, -256, 0);
    queue_req(12869, 256, -256, 0);
    queue_req(-12868, 256, -256, 0);
    queue_req(-12869, 256, -256, 0);
    queue_req(25736, 32767, -32768, 100);
    queue_req(-25736, 32767, -32768, -100);
    queue_req(0, 32767, 0, 0);
    queue_req(0, -32768, 0, 0);
    queue_req(8192, 0, 32767, 0);
    queue_req(-8192, 0, -32768, 0);
    queue_req(0, 0, 0, 32767);
    queue_req(0, 0, 0, -32768);
    wait_idle();

    // full-scale gains drive left into saturation both ways
    write_reg(REG_RADIUS_COEFF, 32'hFFFF);
    write_reg(REG_BASE_COEFF, 32'hFFFF);
    queue_req(0, 32767, 0, 32767);
    queue_req(0, -32768, 0, -32768);
    queue_req(16384, 32767, -32768, 32767);
    queue_req(-16384, -32768, 32767, -32768);
    wait_idle();

    run_phase(16'($urandom), 16'($urandom), 125);
    run_phase(16'd0, 16'hFFFF, 125);

    send_idle_pct = 45;
    recv_idle_pct = 16;
    run_phase(16'hFFFF, 16'd0, 125);

    write_reg(REG_OUTPUT_ENABLE, {31'($urandom), 1'b0});
    queue_random(40);
    wait_idle();
    write_reg(REG_OUTPUT_ENABLE, {31'($urandom), 1'b1});
    run_phase(16'hFFFF, 16'hFFFF, 125);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(16'($urandom), 16'($urandom), 125);
    run_phase(RADIUS_RESET, BASE_RESET, 125);

    if (mismatch_cnt == 0 && pending_tracks.size() == 0)
      $display("track_speed_inverse_kinematics_top_test OK");
    else
      $display("track_speed_inverse_kinematics_top_test NOT OK");
    $finish;
  end

  initial begin
    #1000000;
    $display("track_speed_inverse_kinematics_top_test NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tsik_pkg.sv
sv/tsik_cordic.sv
sv/tsik_mix.sv
sv/track_speed_inverse_kinematics_top.sv
sv/tsik_checker.sv
tb/track_speed_inverse_kinematics_top_test.sv
